FILE: sv/bt_pkg.sv
// Shared types and constants for the stereo cost vector block.
// Used by the controller, the datapath and the top level.
`default_nettype none

package bt_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned COST_W  = 9;
  localparam int unsigned LABEL_W = 6;
  localparam int unsigned RW_W    = 11;
  localparam int unsigned LC_W    = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_VAL_W = 11;

  localparam logic [FUNC_W-1:0] FUNC_LOAD_LEFT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_RIGHT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LABEL_COUNT = 2'd1;

  localparam logic [RW_W-1:0] ROW_WIDTH_RST   = 11'd1024;
  localparam logic [LC_W-1:0] LABEL_COUNT_RST = 7'd64;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [COL_W-1:0]  column;
    logic [PIX_W-1:0]  pixel;
  } in_beat_t;

  typedef struct packed {
    logic [COST_W-1:0]  cost_half;
    logic [LABEL_W-1:0] label;
    logic               last;
    logic               error;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
  } cfg_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RC,
    S_RB,
    S_RF,
    S_HL,
    S_LAB,
    S_ERR
  } bt_state_e;

  typedef enum logic [1:0] {
    RSEL_CTR,
    RSEL_BACK,
    RSEL_FWD
  } rsel_e;

  typedef struct packed {
    logic  in_ready;
    logic  rd_r;
    rsel_e rsel;
    logic  cap_rc;
    logic  cap_back;
    logic  cap_hl;
    logic  rd_l_first;
    logic  emit;
    logic  emit_err;
  } bt_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_compute;
    logic in_col_bad;
    logic out_free;
    logic lab_last;
  } bt_stat_t;

endpackage

`default_nettype wire

FILE: sv/bt_chan_if.sv
// Valid/ready channel carrying one payload beat of type T.
// The payload types come from bt_pkg.
`default_nettype none

interface bt_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport src (output valid, output data, input ready);
  modport snk (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/bt_ctrl.sv
// Sequencing state machine for the stereo cost vector block.
// Depends on bt_pkg for the state, command and status types.
`default_nettype none

module bt_ctrl
  import bt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire bt_stat_t stat_i,
  output bt_cmd_t       cmd_o
);

  bt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rsel = RSEL_CTR;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid && stat_i.in_compute) begin
          state_d = stat_i.in_col_bad ? S_ERR : S_RC;
        end
      end
      S_RC: begin
        cmd_o.rd_r = 1'b1;
        cmd_o.rsel = RSEL_CTR;
        state_d    = S_RB;
      end
      S_RB: begin
        cmd_o.cap_rc = 1'b1;
        cmd_o.rd_r   = 1'b1;
        cmd_o.rsel   = RSEL_BACK;
        state_d      = S_RF;
      end
      S_RF: begin
        cmd_o.cap_back = 1'b1;
        cmd_o.rd_r     = 1'b1;
        cmd_o.rsel     = RSEL_FWD;
        state_d        = S_HL;
      end
      S_HL: begin
        cmd_o.cap_hl     = 1'b1;
        cmd_o.rd_l_first = 1'b1;
        state_d          = S_LAB;
      end
      S_LAB: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.lab_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (stat_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          if (stat_i.lab_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/bt_dp.sv
// Datapath: row stores, configuration registers, right range, cost and output register.
// Depends on bt_pkg and bt_chan_if; driven by commands from bt_ctrl.
`default_nettype none

module bt_dp
  import bt_pkg::*;
#(
  parameter int unsigned MAX_COLS   = 1024,
  parameter int unsigned MAX_LABELS = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bt_chan_if.snk    in_i,
  bt_chan_if.src    out_o,
  bt_chan_if.snk    cfg_i,
  input  wire bt_cmd_t cmd_i,
  output bt_stat_t  stat_o
);

  localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CW = (AW + 1 > RW_W) ? AW + 1 : RW_W;

  logic [PIX_W-1:0] left_mem  [MAX_COLS];
  logic [PIX_W-1:0] right_mem [MAX_COLS];

  logic [RW_W-1:0]    row_width_q;
  logic [LC_W-1:0]    label_count_q;
  logic [CW-1:0]      col_q;
  logic [LABEL_W-1:0] d_q;
  logic [COST_W-1:0]  last_cost_q;
  logic [PIX_W-1:0]   rc_q;
  logic [COST_W-1:0]  back_q;
  logic [COST_W-1:0]  hi_q, lo_q;
  logic [COST_W-1:0]  hi_d, lo_d;
  logic [PIX_W-1:0]   l_rdata_q, r_rdata_q;
  logic               out_valid_q;
  out_beat_t          out_q;

  logic [CW-1:0]      width_eff;
  logic [LC_W-1:0]    lc_eff;
  logic [LABEL_W-1:0] n_m1;
  logic [CW-1:0]      in_col;
  logic               in_fire;
  logic               load_ok;
  logic [CW-1:0]      r_pos;
  logic [CW-1:0]      l_pos;
  logic [CW-1:0]      cur_pos;
  logic               cur_ok;
  logic               l_en;
  logic [COST_W-1:0]  centre;
  logic [COST_W-1:0]  fwd;
  logic [COST_W-1:0]  l2;
  logic [COST_W-1:0]  cost_new;
  logic [COST_W-1:0]  cost_out;
  logic               emit_any;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = cmd_i.in_ready;
  assign in_fire     = cmd_i.in_ready & in_i.valid;
  assign in_col      = CW'(in_i.data.column);

  always_comb begin
    if (CW'(row_width_q) > CW'(MAX_COLS)) begin
      width_eff = CW'(MAX_COLS);
    end else begin
      width_eff = CW'(row_width_q);
    end
    if (label_count_q == '0) begin
      lc_eff = LC_W'(1);
    end else if (label_count_q > LC_W'(MAX_LABELS)) begin
      lc_eff = LC_W'(MAX_LABELS);
    end else begin
      lc_eff = label_count_q;
    end
  end

  assign n_m1    = LABEL_W'(lc_eff - LC_W'(1));
  assign load_ok = in_col < CW'(MAX_COLS);

  assign stat_o.in_valid   = in_i.valid;
  assign stat_o.in_compute = in_i.data.func == FUNC_COMPUTE;
  assign stat_o.in_col_bad = in_col >= width_eff;
  assign stat_o.out_free   = !out_valid_q || out_o.ready;
  assign stat_o.lab_last   = d_q == n_m1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q   <= ROW_WIDTH_RST;
      label_count_q <= LABEL_COUNT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        REG_ROW_WIDTH:   row_width_q   <= cfg_i.data.value;
        REG_LABEL_COUNT: label_count_q <= cfg_i.data.value[LC_W-1:0];
        default: ;
      endcase
    end
  end

  // Row stores: one write port for loads, one registered read port each.
  always_ff @(posedge clk_i) begin
    if (in_fire && load_ok && in_i.data.func == FUNC_LOAD_LEFT) begin
      left_mem[AW'(in_col)] <= in_i.data.pixel;
    end
    if (l_en) begin
      l_rdata_q <= left_mem[AW'(l_pos)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && load_ok && in_i.data.func == FUNC_LOAD_RIGHT) begin
      right_mem[AW'(in_col)] <= in_i.data.pixel;
    end
    if (cmd_i.rd_r) begin
      r_rdata_q <= right_mem[AW'(r_pos)];
    end
  end

  // Right read address; a missing neighbor at a row edge reads the center again.
  always_comb begin
    case (cmd_i.rsel)
      RSEL_BACK: r_pos = (col_q != '0) ? col_q - CW'(1) : col_q;
      RSEL_FWD:  r_pos = (col_q + CW'(1) < width_eff) ? col_q + CW'(1) : col_q;
      default:   r_pos = col_q;
    endcase
  end

  assign cur_pos = col_q + CW'(d_q);
  assign cur_ok  = cur_pos < width_eff;
  assign l_pos   = cur_pos + CW'(cmd_i.emit);
  assign l_en    = (cmd_i.rd_l_first | cmd_i.emit) & (l_pos < width_eff);

  assign centre = {rc_q, 1'b0};
  assign fwd    = COST_W'(rc_q) + COST_W'(r_rdata_q);
  assign l2     = {l_rdata_q, 1'b0};

  always_comb begin
    if (l2 > hi_q) begin
      cost_new = l2 - hi_q;
    end else if (lo_q > l2) begin
      cost_new = lo_q - l2;
    end else begin
      cost_new = '0;
    end
    if (cmd_i.emit_err) begin
      cost_out = '0;
    end else if (cur_ok) begin
      cost_out = cost_new;
    end else begin
      cost_out = last_cost_q;
    end
  end

  always_comb begin
    hi_d = centre;
    lo_d = centre;
    if (back_q > centre && back_q >= fwd) begin
      hi_d = back_q;
    end else if (fwd > centre) begin
      hi_d = fwd;
    end
    if (back_q < centre && back_q <= fwd) begin
      lo_d = back_q;
    end else if (fwd < centre) begin
      lo_d = fwd;
    end
  end

  assign emit_any = cmd_i.emit | cmd_i.emit_err;

  // Right value range, built over three reads of the right store.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      col_q <= in_col;
    end
    if (cmd_i.cap_rc) begin
      rc_q <= r_rdata_q;
    end
    if (cmd_i.cap_back) begin
      back_q <= (col_q != '0) ? COST_W'(rc_q) + COST_W'(r_rdata_q) : centre;
    end
    if (cmd_i.cap_hl) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q         <= '0;
      last_cost_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        d_q <= '0;
        if (stat_o.in_compute && stat_o.in_col_bad) begin
          last_cost_q <= '0;
        end
      end else if (emit_any) begin
        d_q <= d_q + LABEL_W'(1);
      end
      if (cmd_i.emit && cur_ok) begin
        last_cost_q <= cost_new;
      end
      if (emit_any) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_any) begin
      out_q.cost_half <= cost_out;
      out_q.label     <= d_q;
      out_q.last      <= stat_o.lab_last;
      out_q.error     <= cmd_i.emit_err;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

FILE: sv/stereo_bt_cost_vector.sv
// Top level of the stereo cost vector block: Birchfield-Tomasi costs for one image row.
// Depends on bt_pkg and bt_chan_if; instantiates bt_ctrl and bt_dp.
//
// Channels: in_i takes beats of func, column and pixel. A load beat writes one pixel
// into the left or right row store; loads to columns beyond the store and unused func
// codes are dropped. A compute beat names a column c and yields label_count result
// beats on out_o, one per disparity, with last on the final one (label_count clamped to
// 1..MAX_LABELS). cfg_i writes row_width (index 0) or label_count (index 1) and is
// always ready; the user must write it only while the block is idle, which the block
// itself does not enforce. A compute beat fetches the right neighborhood through the
// single read port of the right store in states RC, RB and RF and forms its range in
// HL, then emits one cost per cycle while out_o accepts, as the left store port
// streams c+d. A bad column skips the fetch and emits its error vector at one beat per
// cycle. in_i is held off while a vector is in progress. The output register lets the
// next item be taken while the final beat still waits. When out_o stalls, the sequence
// pauses with the pending left pixel held in the read register.
// Reset clears the controller, the counters and the output valid and restores
// row_width 1024 and label_count 64; the row stores keep their contents.
`default_nettype none

module stereo_bt_cost_vector
  import bt_pkg::*;
#(
  parameter int unsigned MAX_COLS   = 1024,
  parameter int unsigned MAX_LABELS = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bt_chan_if.snk    in_i,
  bt_chan_if.src    out_o,
  bt_chan_if.snk    cfg_i
);

  bt_cmd_t  cmd;
  bt_stat_t stat;

  bt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  bt_dp #(
    .MAX_COLS   (MAX_COLS),
    .MAX_LABELS (MAX_LABELS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule

`default_nettype wire
